### design/glt_pkg.sv
// Package for the grammar token lexer: token kinds, result records,
// character constants and character-class helpers.
// No dependencies.
package glt_pkg;

  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = 3;
  localparam int QCNT_W  = 4;
  localparam int LVL_BUSY_MAX = QDEPTH - 2 * MAX_RES;
  localparam int LVL_IDLE_MAX = QDEPTH - MAX_RES;

  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_ILLEGAL = 4'd1,
    KIND_OPEN    = 4'd2,
    KIND_CLOSE   = 4'd3,
    KIND_OR      = 4'd4,
    KIND_SEMI    = 4'd5,
    KIND_ASSOC   = 4'd6,
    KIND_LITERAL = 4'd7,
    KIND_IDENT   = 4'd8,
    KIND_KEYWORD = 4'd9
  } kind_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0]               cnt;
    tok_t [MAX_RES-1:0]       tok;
  } push_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [2:0] KW_LEN    = 3'd5;
  localparam logic [2:0] PROG_FAIL = 3'd7;

  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h6B;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_ident_cont(logic [7:0] b);
    return is_alpha(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_USCORE);
  endfunction

  function automatic logic is_space_cont(logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

### design/glt_if.sv
// Channel interfaces of the grammar token lexer: byte input and token output.
// No dependencies.
interface glt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_end;

  modport source (output valid, text_byte, is_end, input ready);
  modport sink   (input valid, text_byte, is_end, output ready);
endinterface

interface glt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, token_start, token_length, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, token_start, token_length, last_of_run,
                  output ready);
endinterface

### design/grammar_token_lexer_unit.sv
// Grammar token lexer, top level. A byte is registered in the core's input
// register on its input transaction; its tokens are then written into the
// 8-entry output queue, whose head is offered. Throughput: one byte per cycle
// while the output drains one token per cycle and the queue has room; the
// queue keeps room for three tokens per byte in flight. Reset (rst_n, synchronous,
// low) clears scan state, position and the queue. Depends on glt_core, glt_outq, glt_pkg, glt_if.
module grammar_token_lexer_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  glt_in_if.sink    in_chan,
  glt_out_if.source out_chan
);
  import glt_pkg::*;

  push_t             push_s;
  logic [QCNT_W-1:0] level_s;

  glt_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_level (level_s),
    .push    (push_s)
  );

  glt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_s),
    .out_chan (out_chan),
    .level    (level_s)
  );

endmodule

### design/glt_outq.sv
// Output queue of the grammar token lexer: takes up to three tokens a cycle,
// delivers one per output transaction. Depends on glt_pkg and glt_if.
module glt_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  glt_pkg::push_t            push,
  glt_out_if.source                 out_chan,
  output logic [glt_pkg::QCNT_W-1:0] level
);
  import glt_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  tok_t              head;

  assign pop        = out_chan.valid && out_chan.ready;
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wr_ptr_r + QPTR_W'(i)] <= push.tok[i];
      end
    end
  end

  assign head                  = mem_r[rd_ptr_r];
  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.token_kind   = head.token_kind;
  assign out_chan.token_start  = head.token_start;
  assign out_chan.token_length = head.token_length;
  assign out_chan.last_of_run  = head.last_of_run;
  assign level                 = cnt_r;

endmodule

### design/glt_core.sv
// Lexer core of the grammar token lexer: input register, scan state and token
// generation, one byte per cycle while the queue has room. Depends on glt_pkg and glt_if.
module glt_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  glt_in_if.sink                     in_chan,
  input  logic [glt_pkg::QCNT_W-1:0] q_level,
  output glt_pkg::push_t             push
);
  import glt_pkg::*;

  localparam int WB = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  typedef logic [OFFSET_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_SPACE  = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_LIT    = 6'b001000,
    MODE_COLON1 = 6'b010000,
    MODE_COLON2 = 6'b100000
  } mode_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic pos_t span(pos_t from, pos_t to);
    return (to >= from) ? to - from : '0;
  endfunction

  function automatic logic [15:0] clamp16(pos_t v);
    logic [WB-1:0] w;
    w = WB'(v);
    return (w > WB'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t mk_tok(kind_t k, pos_t s, pos_t l);
    tok_t t;
    t.token_kind   = k;
    t.token_start  = clamp16(s);
    t.token_length = clamp16(l);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  logic        stage_vld_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic        accept;

  mode_t       mode_r, mode_nxt;
  logic        dq_r, dq_nxt;
  pos_t        pos_r, pos_nxt;
  pos_t        tb_r, tb_nxt;
  logic [2:0]  kp_r, kp_nxt;

  tok_t [MAX_RES-1:0] tok_s;
  logic [1:0]         n_s;
  logic               do_idle;
  logic [7:0]         quote_ch;

  assign in_chan.ready = stage_vld_r ? (q_level <= QCNT_W'(LVL_BUSY_MAX))
                                     : (q_level <= QCNT_W'(LVL_IDLE_MAX));
  assign accept   = in_chan.valid && in_chan.ready;
  assign quote_ch = dq_r ? CH_DQUOTE : CH_SQUOTE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      dq_r        <= 1'b0;
      pos_r       <= '0;
      tb_r        <= '0;
      kp_r        <= '0;
    end else begin
      stage_vld_r <= accept;
      mode_r      <= mode_nxt;
      dq_r        <= dq_nxt;
      pos_r       <= pos_nxt;
      tb_r        <= tb_nxt;
      kp_r        <= kp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_chan.text_byte;
      end_r  <= in_chan.is_end;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    dq_nxt   = dq_r;
    pos_nxt  = pos_r;
    tb_nxt   = tb_r;
    kp_nxt   = kp_r;
    tok_s    = '0;
    n_s      = '0;
    do_idle  = 1'b0;

    if (stage_vld_r) begin
      if (end_r) begin
        unique case (mode_r)
          MODE_IDENT: begin
            tok_s[n_s] = mk_tok((kp_r == KW_LEN) ? KIND_KEYWORD : KIND_IDENT,
                                tb_r, span(tb_r, pos_r));
            n_s = n_s + 2'd1;
          end
          MODE_LIT: begin
            tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_r, span(tb_r, pos_r));
            n_s = n_s + 2'd1;
          end
          MODE_COLON1: begin
            tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_r, pos_t'(1));
            n_s = n_s + 2'd1;
          end
          MODE_COLON2: begin
            tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_r, pos_t'(1));
            n_s = n_s + 2'd1;
            tok_s[n_s] = mk_tok(KIND_ILLEGAL, sat_inc(tb_r), pos_t'(1));
            n_s = n_s + 2'd1;
          end
          default: ;
        endcase
        tok_s[n_s] = mk_tok(KIND_EOF, pos_r, '0);
        n_s      = n_s + 2'd1;
        mode_nxt = MODE_IDLE;
        dq_nxt   = 1'b0;
        pos_nxt  = '0;
        tb_nxt   = '0;
        kp_nxt   = '0;
      end else begin
        unique case (mode_r)
          MODE_SPACE: begin
            do_idle = !is_space_cont(byte_r);
          end
          MODE_IDENT: begin
            if (is_ident_cont(byte_r)) begin
              if ((kp_r < KW_LEN) && (byte_r == kw_char(kp_r))) begin
                kp_nxt = kp_r + 3'd1;
              end else begin
                kp_nxt = PROG_FAIL;
              end
            end else begin
              tok_s[n_s] = mk_tok((kp_r == KW_LEN) ? KIND_KEYWORD : KIND_IDENT,
                                  tb_r, span(tb_r, pos_r));
              n_s     = n_s + 2'd1;
              do_idle = 1'b1;
            end
          end
          MODE_LIT: begin
            if (byte_r == quote_ch) begin
              tok_s[n_s] = mk_tok(KIND_LITERAL, tb_r, span(tb_r, pos_r));
              n_s      = n_s + 2'd1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_COLON1: begin
            if (byte_r == CH_COLON) begin
              mode_nxt = MODE_COLON2;
            end else begin
              tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_r, pos_t'(1));
              n_s     = n_s + 2'd1;
              do_idle = 1'b1;
            end
          end
          MODE_COLON2: begin
            if (byte_r == CH_EQ) begin
              tok_s[n_s] = mk_tok(KIND_ASSOC, tb_r, pos_t'(3));
              n_s      = n_s + 2'd1;
              mode_nxt = MODE_IDLE;
            end else begin
              tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_r, pos_t'(1));
              n_s    = n_s + 2'd1;
              tb_nxt = sat_inc(tb_r);
              if (byte_r != CH_COLON) begin
                tok_s[n_s] = mk_tok(KIND_ILLEGAL, tb_nxt, pos_t'(1));
                n_s     = n_s + 2'd1;
                do_idle = 1'b1;
              end
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        if (do_idle) begin
          mode_nxt = MODE_IDLE;
          case (byte_r) inside
            CH_SP, CH_TAB, CH_LF: begin
              mode_nxt = MODE_SPACE;
            end
            CH_LBRACE: begin
              tok_s[n_s] = mk_tok(KIND_OPEN, pos_r, pos_t'(1));
              n_s = n_s + 2'd1;
            end
            CH_RBRACE: begin
              tok_s[n_s] = mk_tok(KIND_CLOSE, pos_r, pos_t'(1));
              n_s = n_s + 2'd1;
            end
            CH_BAR: begin
              tok_s[n_s] = mk_tok(KIND_OR, pos_r, pos_t'(1));
              n_s = n_s + 2'd1;
            end
            CH_SEMI: begin
              tok_s[n_s] = mk_tok(KIND_SEMI, pos_r, pos_t'(1));
              n_s = n_s + 2'd1;
            end
            CH_COLON: begin
              mode_nxt = MODE_COLON1;
              tb_nxt   = pos_r;
            end
            CH_SQUOTE, CH_DQUOTE: begin
              mode_nxt = MODE_LIT;
              dq_nxt   = (byte_r == CH_DQUOTE);
              tb_nxt   = sat_inc(pos_r);
            end
            default: begin
              if (is_alpha(byte_r) || (byte_r == CH_USCORE)) begin
                mode_nxt = MODE_IDENT;
                tb_nxt   = pos_r;
                kp_nxt   = (byte_r == kw_char(3'd0)) ? 3'd1 : PROG_FAIL;
              end else begin
                tok_s[n_s] = mk_tok(KIND_ILLEGAL, pos_r, pos_t'(1));
                n_s = n_s + 2'd1;
              end
            end
          endcase
        end
        pos_nxt = sat_inc(pos_r);
      end
    end

    for (int i = 0; i < MAX_RES; i++) begin
      tok_s[i].last_of_run = (n_s == 2'(i + 1));
    end
  end

  assign push.cnt = n_s;
  assign push.tok = tok_s;

endmodule
